[design/cicl_pkg.sv]
package cicl_pkg;

  localparam int CAPACITY    = 64;
  localparam int ENTRY_WIDTH = 32;
  localparam int COUNT_W     = $clog2(CAPACITY + 1);
  localparam int IDX_W       = 6;
  localparam int CMP_W       = (COUNT_W > IDX_W) ? COUNT_W : IDX_W;

  typedef enum logic [1:0] {
    KIND_APPEND = 2'd0,
    KIND_SET    = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_GET    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BOUNDS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  // request broadcast to every cell, already qualified by accept and bounds
  typedef struct packed {
    logic                   app;
    logic                   set;
    logic                   rm;
    logic                   rd;
    logic [CMP_W-1:0]       idx;
    logic [CMP_W-1:0]       cnt;
    logic [ENTRY_WIDTH-1:0] data;
  } cmd_t;

endpackage

[design/cicl_cell.sv]
module cicl_cell import cicl_pkg::*; (
  input  logic                   clk,
  input  cmd_t                   cmd,
  input  logic [CMP_W-1:0]       cell_pos,
  input  logic [ENTRY_WIDTH-1:0] up_data,
  output logic [ENTRY_WIDTH-1:0] data_out,
  output logic [ENTRY_WIDTH-1:0] rd_out
);

  logic [ENTRY_WIDTH-1:0] data_r, data_nxt;
  logic [ENTRY_WIDTH-1:0] rd_r, rd_nxt;
  logic                   hit;

  assign hit = (cell_pos == cmd.idx);

  always_comb begin
    data_nxt = data_r;
    if (cmd.app && (cell_pos == cmd.cnt)) begin
      data_nxt = cmd.data;
    end else if (cmd.set && hit) begin
      data_nxt = cmd.data;
    end else if (cmd.rm && (cell_pos >= cmd.idx)) begin
      // compacting shift: take the neighbor's word
      data_nxt = up_data;
    end
  end

  // only the addressed cell puts its word on the read tree
  assign rd_nxt = (cmd.rd && hit) ? data_r : '0;

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
    rd_r   <= rd_nxt;
  end

  assign data_out = data_r;
  assign rd_out   = rd_r;

endmodule

[design/compacting_indexed_list_core.sv]
// Ordered list of up to CAPACITY words held in a row of cells, one word per
// cell. Requests are append, set, remove (later words shift down one cell) and
// get; each gives one result word with status, read data and the count after
// the request. Every request, remove included, is applied to all cells at the
// edge it is accepted, so a new request can be taken every cycle that in_stall is
// low; a result is first registered in the middle stage, with the cells' read
// word, then goes through the OR tree over the cells into the output stage. A stalled
// result holds one further request in the middle stage before in_stall rises.
module compacting_indexed_list_core import cicl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_kind,
  input  logic [5:0]  in_index,
  input  logic [31:0] in_write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [31:0] out_read_data,
  output logic [6:0]  out_count
);

  logic                   in_acc;
  logic                   full, oob;
  kind_t                  kind;
  status_t                status_nxt;
  cmd_t                   cmd;
  logic [COUNT_W-1:0]     count_r, count_nxt;

  logic                   pend_r, pend_nxt;
  status_t                pend_status_r, pend_status_nxt;
  logic [COUNT_W-1:0]     pend_count_r, pend_count_nxt;
  logic [31:0]            pend_data_r, pend_data_nxt;
  logic                   rd_fresh_r, rd_fresh_nxt;
  logic [31:0]            pend_rd;
  logic                   pend_move;

  logic                   out_valid_r, out_valid_nxt;
  status_t                out_status_r, out_status_nxt;
  logic [31:0]            out_data_r, out_data_nxt;
  logic [COUNT_W-1:0]     out_count_r, out_count_nxt;

  logic [ENTRY_WIDTH-1:0] cell_data [CAPACITY];
  logic [ENTRY_WIDTH-1:0] cell_rd   [CAPACITY];
  logic [ENTRY_WIDTH-1:0] rd_or;

  assign pend_move = pend_r && (!out_valid_r || !out_stall);
  assign in_stall  = pend_r && !pend_move;
  assign in_acc    = in_valid && !in_stall;

  assign kind = kind_t'(in_kind);
  assign full = (count_r == COUNT_W'(CAPACITY));
  assign oob  = (CMP_W'(in_index) >= CMP_W'(count_r));

  always_comb begin
    cmd      = '0;
    cmd.idx  = CMP_W'(in_index);
    cmd.cnt  = CMP_W'(count_r);
    cmd.data = ENTRY_WIDTH'(in_write_data);
    status_nxt = ST_OK;
    count_nxt  = count_r;
    case (kind)
      KIND_APPEND: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          cmd.app = in_acc;
          if (in_acc) count_nxt = count_r + COUNT_W'(1);
        end
      end
      KIND_SET: begin
        if (oob) status_nxt = ST_BOUNDS;
        else     cmd.set = in_acc;
      end
      KIND_REMOVE: begin
        if (oob) begin
          status_nxt = ST_BOUNDS;
        end else begin
          cmd.rm = in_acc;
          if (in_acc) count_nxt = count_r - COUNT_W'(1);
        end
      end
      KIND_GET: begin
        if (oob) status_nxt = ST_BOUNDS;
        else     cmd.rd = in_acc;
      end
      default: status_nxt = ST_OK;
    endcase
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic [ENTRY_WIDTH-1:0] up_data;
      if (gi == CAPACITY - 1) begin : g_top
        assign up_data = cell_data[gi];
      end else begin : g_mid
        assign up_data = cell_data[gi+1];
      end
      cicl_cell u_cell (
        .clk      (clk),
        .cmd      (cmd),
        .cell_pos (CMP_W'(gi)),
        .up_data  (up_data),
        .data_out (cell_data[gi]),
        .rd_out   (cell_rd[gi])
      );
    end
  endgenerate

  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
  end

  // the cells show the read word for one cycle only, so keep it while stalled
  assign rd_fresh_nxt = in_acc;
  assign pend_rd      = rd_fresh_r ? 32'(rd_or) : pend_data_r;

  always_comb begin
    pend_nxt        = pend_r;
    pend_status_nxt = pend_status_r;
    pend_count_nxt  = pend_count_r;
    pend_data_nxt   = pend_rd;
    if (pend_move) pend_nxt = 1'b0;
    if (in_acc) begin
      pend_nxt        = 1'b1;
      pend_status_nxt = status_nxt;
      pend_count_nxt  = count_nxt;
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_data_nxt   = out_data_r;
    out_count_nxt  = out_count_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (pend_move) begin
      out_valid_nxt  = 1'b1;
      out_status_nxt = pend_status_r;
      out_data_nxt   = pend_rd;
      out_count_nxt  = pend_count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      rd_fresh_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      pend_r      <= pend_nxt;
      rd_fresh_r  <= rd_fresh_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_status_r <= pend_status_nxt;
    pend_count_r  <= pend_count_nxt;
    pend_data_r   <= pend_data_nxt;
    out_status_r  <= out_status_nxt;
    out_data_r    <= out_data_nxt;
    out_count_r   <= out_count_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_read_data = out_data_r;
  assign out_count     = 7'(out_count_r);

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_fail_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (status_nxt != ST_OK)) |=> (count_r == $past(count_r)))
    else $error("failed request changed the count");

  a_data_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r != 32'd0)) |-> (out_status_r == ST_OK))
    else $error("read word on a failed request");

  a_pend_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (pend_r && (pend_count_r == count_r)))
    else $error("pending count differs from list count");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r && out_valid_r && out_stall) |-> in_stall)
    else $error("request taken while both result stages are full");

endmodule

[test/compacting_indexed_list_core_tb.sv]
`timescale 1ns / 1ps

module compacting_indexed_list_core_tb;
  import cicl_pkg::*;

  localparam int RANDOM_REQUESTS = 750;
  localparam int WATCHDOG_LIMIT  = 1000;
  localparam int DRAIN_CYCLES    = 8;
  localparam int MAX_GAP         = 10;

  typedef struct packed {
    status_t                status;
    logic [ENTRY_WIDTH-1:0] read_data;
    logic [6:0]             count;
  } list_result_t;

  typedef enum {FILLING, DRAINING, MIXED} traffic_phase_t;

  // shadow copy of the list plus the results still owed by the block
  class list_tracker;
    logic [ENTRY_WIDTH-1:0] cells [CAPACITY];
    int                     n_entries = 0;
    list_result_t           expected_results [$];
    int                     mismatches = 0;

    task report(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      mismatches++;
    endtask

    function void apply_request(kind_t kind, logic [5:0] idx, logic [31:0] wdata);
      list_result_t r;
      r.status    = ST_OK;
      r.read_data = '0;
      if (kind == KIND_APPEND) begin
        if (n_entries >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          cells[n_entries] = wdata[ENTRY_WIDTH-1:0];
          n_entries++;
        end
      end else if (idx >= n_entries) begin
        r.status = ST_BOUNDS;
      end else begin
        case (kind)
          KIND_SET: cells[idx] = wdata[ENTRY_WIDTH-1:0];
          KIND_REMOVE: begin
            // later entries slide down one cell
            for (int i = idx; i + 1 < n_entries; i++) cells[i] = cells[i + 1];
            n_entries--;
          end
          default: r.read_data = cells[idx];
        endcase
      end
      r.count = n_entries[6:0];
      expected_results.push_back(r);
    endfunction

    task check_result(logic [1:0] status, logic [31:0] rdata, logic [6:0] count);
      list_result_t exp;
      if (expected_results.size() == 0) begin
        report($sformatf("result word with no request pending (status %0d count %0d)",
                         status, count));
        return;
      end
      exp = expected_results.pop_front();
      if (status !== exp.status)
        report($sformatf("status %0d, expected %0d", status, exp.status));
      if (rdata !== exp.read_data)
        report($sformatf("read_data %h, expected %h", rdata, exp.read_data));
      if (count !== exp.count)
        report($sformatf("count %0d, expected %0d", count, exp.count));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_kind;
  logic [5:0]  in_index;
  logic [31:0] in_write_data;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic [31:0] out_read_data;
  logic [6:0]  out_count;

  list_tracker tracker = new;
  bit          quiet_in;
  bit          quiet_out;
  int          idle_cycles = 0;

  compacting_indexed_list_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_index      (in_index),
    .in_write_data (in_write_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_status    (out_status),
    .out_read_data (out_read_data),
    .out_count     (out_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("compacting_indexed_list_core_tb: FAIL");
      $finish;
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task send_request(kind_t kind, logic [5:0] idx, logic [31:0] wdata);
    int gap;
    if ($urandom_range(0, 29) == 0) quiet_in = !quiet_in;
    gap = quiet_in ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_index      <= idx;
    in_write_data <= wdata;
    do @(posedge clk); while (in_stall);
    tracker.apply_request(kind, idx, wdata);
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 9))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [5:0] pick_index(int count);
    if (count > 0 && $urandom_range(0, 4) != 0) return 6'($urandom_range(0, count - 1));
    return 6'($urandom_range(0, 63));
  endfunction

  task automatic run_random();
    traffic_phase_t phase = FILLING;
    int             full_hits = 0;
    int             mixed_left = 0;
    kind_t          kind;
    int             count;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      count = tracker.n_entries;
      case (phase)
        FILLING: begin
          kind = ($urandom_range(0, 99) < 75) ? KIND_APPEND : kind_t'($urandom_range(1, 3));
          if (count == CAPACITY) full_hits++;
          // appends bounce off the full list; after four requests meet it full, draining starts
          if (full_hits >= 4) begin
            phase     = DRAINING;
            full_hits = 0;
          end
        end
        DRAINING: begin
          kind = ($urandom_range(0, 99) < 70) ? KIND_REMOVE : kind_t'($urandom_range(0, 3));
          if (count == 0) begin
            phase      = MIXED;
            mixed_left = $urandom_range(40, 100);
          end
        end
        default: begin
          kind = kind_t'($urandom_range(0, 3));
          mixed_left--;
          if (mixed_left <= 0) phase = FILLING;
        end
      endcase
      send_request(kind, pick_index(count), pick_word());
    end
  endtask

  // result side: random stall before taking each word
  initial begin
    int hold;
    out_stall = 1'b0;
    @(posedge rst_n);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 29) == 0) quiet_out = !quiet_out;
      hold = quiet_out ? 0 : $urandom_range(0, MAX_GAP);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      tracker.check_result(out_status, out_read_data, out_count);
      @(negedge clk);
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_kind       = KIND_APPEND;
    in_index      = '0;
    in_write_data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // empty list, out-of-range ops, append ignoring index
    send_request(KIND_GET,    6'd0,  32'h1234_5678);
    send_request(KIND_REMOVE, 6'd0,  32'h0);
    send_request(KIND_SET,    6'd63, 32'hFFFF_FFFF);
    send_request(KIND_APPEND, 6'd63, 32'h0000_0000);
    send_request(KIND_APPEND, 6'd0,  32'hFFFF_FFFF);
    send_request(KIND_APPEND, 6'd21, 32'hA5A5_A5A5);
    send_request(KIND_GET,    6'd0,  32'hFFFF_FFFF);
    send_request(KIND_GET,    6'd1,  32'h0);
    send_request(KIND_GET,    6'd3,  32'h0);
    send_request(KIND_SET,    6'd2,  32'h5A5A_5A5A);
    send_request(KIND_GET,    6'd2,  32'h0);
    // remove from the front shifts the rest down
    send_request(KIND_REMOVE, 6'd0,  32'hFFFF_FFFF);
    send_request(KIND_GET,    6'd0,  32'h0);
    send_request(KIND_GET,    6'd1,  32'h0);
    // remove of the last entry
    send_request(KIND_REMOVE, 6'd1,  32'h0);
    send_request(KIND_GET,    6'd1,  32'h0);
    send_request(KIND_SET,    6'd0,  32'h0000_0000);
    send_request(KIND_GET,    6'd0,  32'hFFFF_FFFF);
    send_request(KIND_REMOVE, 6'd0,  32'h0);
    send_request(KIND_GET,    6'd42, 32'h0);

    run_random();
    in_valid <= 1'b0;

    while (tracker.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("compacting_indexed_list_core_tb: PASS");
    end else begin
      $display("compacting_indexed_list_core_tb: FAIL");
    end
    $finish;
  end

endmodule

[compacting_indexed_list_core.f]
design/cicl_pkg.sv
design/cicl_cell.sv
design/compacting_indexed_list_core.sv
test/compacting_indexed_list_core_tb.sv
